[rtl/tea_block_cipher_defines.svh]
// Assertion macros shared by the TEA block cipher checkers.
`ifndef TEA_BLOCK_CIPHER_DEFINES_SVH
`define TEA_BLOCK_CIPHER_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define TEA_ASSERT_IMPL(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define TEA_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define TEA_ASSERT_ALWAYS_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) (pre) |=> (post)) \
      else $error(msg);

`endif

[rtl/tea_pkg.sv]
// Types, constants and round function for the TEA block cipher.
package tea_pkg;

   localparam int unsigned TEA_ROUNDS = 32;
   localparam logic [31:0] TEA_DELTA  = 32'h9e3779b9;

   localparam int unsigned CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_ZERO  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_ONE   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_TWO   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_THREE = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODE      = 3'd4;

   typedef struct packed {
      logic [31:0] first_word;
      logic [31:0] second_word;
   } req_type;

   typedef struct packed {
      logic [31:0] first_result;
      logic [31:0] second_result;
   } rsp_type;

   typedef struct packed {
      logic [31:0] first_half;
      logic [31:0] second_half;
   } blk_type;

   typedef struct packed {
      logic [31:0] key_word_zero;
      logic [31:0] key_word_one;
      logic [31:0] key_word_two;
      logic [31:0] key_word_three;
      logic        decrypt_mode;
   } cfg_type;

   function automatic logic [31:0] tea_mix(input logic [31:0] half,
                                           input logic [31:0] sum,
                                           input logic [31:0] kl,
                                           input logic [31:0] kr);
      return ((half << 4) + kl) ^ (half + sum) ^ ((half >> 5) + kr);
   endfunction

endpackage

[rtl/tea_cell.sv]
// One half-round cell of the TEA pipeline with its own valid/ready stage.
module tea_cell
   import tea_pkg::*;
#(
   parameter int unsigned ROUNDS      = TEA_ROUNDS,
   parameter int unsigned ROUND_INDEX = 0,
   parameter bit          HALF        = 1'b0
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    in_valid,
   output logic    in_ready,
   input  blk_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output blk_type out_data
);

   localparam logic [31:0] ENC_SUM = TEA_DELTA * 32'(ROUND_INDEX + 1);
   localparam logic [31:0] DEC_SUM = TEA_DELTA * 32'(ROUNDS - ROUND_INDEX);

   logic        valid_ff;
   logic        valid_in;
   blk_type     data_ff;
   blk_type     data_in;
   logic        update_first;
   logic [31:0] src;
   logic [31:0] dst;
   logic [31:0] kl;
   logic [31:0] kr;
   logic [31:0] sum;
   logic [31:0] mixed;
   logic [31:0] res;

   // encrypt: even cells update the first half; decrypt swaps the order
   assign update_first = (HALF == 1'b0) ^ cfg.decrypt_mode;

   assign src   = update_first ? in_data.second_half : in_data.first_half;
   assign dst   = update_first ? in_data.first_half  : in_data.second_half;
   assign kl    = update_first ? cfg.key_word_zero   : cfg.key_word_two;
   assign kr    = update_first ? cfg.key_word_one    : cfg.key_word_three;
   assign sum   = cfg.decrypt_mode ? DEC_SUM : ENC_SUM;
   assign mixed = tea_mix(src, sum, kl, kr);
   assign res   = cfg.decrypt_mode ? (dst - mixed) : (dst + mixed);

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_ready) begin
         valid_in = in_valid;
         if (in_valid) begin
            data_in.first_half  = update_first ? res : in_data.first_half;
            data_in.second_half = update_first ? in_data.second_half : res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[rtl/tea_block_cipher.sv]
// Top level of the TEA block cipher: config registers and the chain of cells.
//
//   port group  dir  beat contents
//   req_*       in   one 64-bit block (first_word, second_word)
//   rsp_*       out  one transformed block (first_result, second_result)
//   csr_*       in   register index and 32-bit write data
//
// One block per cycle while rsp_ready does not stall the chain; each
// half-round cell registers the block. Reset clears the key and mode registers
// and all cell valid bits. A stalled result backs up cell by cell; empty cells
// keep taking new blocks. csr writes are taken every cycle.
module tea_block_cipher
   import tea_pkg::*;
#(
   parameter int unsigned ROUNDS = TEA_ROUNDS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_type                    rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0]                csr_wdata
);

   localparam int unsigned CELLS = 2 * ROUNDS;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    valid [CELLS+1];
   logic    ready [CELLS+1];
   blk_type data  [CELLS+1];

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_KEY_ZERO:  cfg_in.key_word_zero  = csr_wdata;
            CSR_KEY_ONE:   cfg_in.key_word_one   = csr_wdata;
            CSR_KEY_TWO:   cfg_in.key_word_two   = csr_wdata;
            CSR_KEY_THREE: cfg_in.key_word_three = csr_wdata;
            CSR_MODE:      cfg_in.decrypt_mode   = csr_wdata[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign valid[0]            = req_valid;
   assign req_ready           = ready[0];
   assign data[0].first_half  = req_data.first_word;
   assign data[0].second_half = req_data.second_word;

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      tea_cell #(
         .ROUNDS      (ROUNDS),
         .ROUND_INDEX (i / 2),
         .HALF        (1'(i % 2))
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cfg       (cfg_ff),
         .in_valid  (valid[i]),
         .in_ready  (ready[i]),
         .in_data   (data[i]),
         .out_valid (valid[i+1]),
         .out_ready (ready[i+1]),
         .out_data  (data[i+1])
      );
   end

   assign rsp_valid              = valid[CELLS];
   assign ready[CELLS]           = rsp_ready;
   assign rsp_data.first_result  = data[CELLS].first_half;
   assign rsp_data.second_result = data[CELLS].second_half;

endmodule

[rtl/tea_checker.sv]
// Port-level checks for the TEA block cipher, bound to the top level.
`include "tea_block_cipher_defines.svh"

module tea_checker
   import tea_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data,
   input logic    csr_ready
);

   `TEA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp beat dropped or changed while stalled")
   `TEA_ASSERT_ALWAYS_NEXT(a_rsp_reset, reset, !rsp_valid, "rsp_valid high right after reset")
   `TEA_ASSERT_IMPL(a_req_flow, !rsp_valid || rsp_ready, req_ready, "req side blocked while rsp side is free")
   `TEA_ASSERT_IMPL(a_csr_open, 1'b1, csr_ready, "csr write refused")

endmodule

bind tea_block_cipher tea_checker u_tea_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .csr_ready (csr_ready)
);
